// ===== sv/xrg_pkg.sv =====
`timescale 1ns / 1ps

package xrg_pkg;

    localparam int WORD_W = 64;
    localparam int HALF_W = 32;
    localparam int CNT_W  = $clog2(WORD_W);
    localparam int IDX_W  = 2;

    localparam logic [1:0] VAR_XS32  = 2'd0;
    localparam logic [1:0] VAR_XS64  = 2'd1;

    localparam logic [IDX_W-1:0] REG_VARIANT = 2'd0;
    localparam logic [IDX_W-1:0] REG_SEED_A  = 2'd1;
    localparam logic [IDX_W-1:0] REG_SEED_B  = 2'd2;

    localparam logic [1:0]        RST_VARIANT = VAR_XS32;
    localparam logic [WORD_W-1:0] RST_SEED_A  = 64'd2525;
    localparam logic [WORD_W-1:0] RST_SEED_B  = 64'd987654321;

    localparam logic [WORD_W-1:0] ZERO_FIX_A = 64'd1;
    localparam logic [WORD_W-1:0] ZERO_FIX_B = 64'd2;

    localparam int XS32_SH1  = 13;
    localparam int XS32_SH2  = 17;
    localparam int XS32_SH3  = 5;
    localparam int XS64_SH1  = 13;
    localparam int XS64_SH2  = 7;
    localparam int XS64_SH3  = 17;
    localparam int XS128_SH1 = 23;
    localparam int XS128_SH2 = 17;
    localparam int XS128_SH3 = 26;

    typedef struct packed {
        logic              cmd;
        logic [WORD_W-1:0] range_low;
        logic [WORD_W-1:0] range_high;
    } t_in;

    typedef struct packed {
        logic [WORD_W-1:0] value;
        logic              bad_range;
    } t_out;

    typedef enum logic [1:0] {
        S_IDLE,
        S_GEN,
        S_DIV,
        S_WRITE
    } t_state;

    typedef struct packed {
        logic load_in;
        logic gen;
        logic div_step;
        logic wr_out;
    } t_cmd;

    typedef struct packed {
        logic skip_div;
        logic div_last;
        logic out_free;
    } t_sts;

endpackage

// ===== sv/xrg_ctrl.sv =====
`timescale 1ns / 1ps

module xrg_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  xrg_pkg::t_sts i_sts,
    output logic          o_in_ready,
    output xrg_pkg::t_cmd o_cmd
);
    import xrg_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        o_cmd      = '0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state       = S_GEN;
                end
            end
            S_GEN: begin
                o_cmd.gen = 1'b1;
                n_state   = i_sts.skip_div ? S_WRITE : S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_last) begin
                    n_state = S_WRITE;
                end
            end
            S_WRITE: begin
                if (i_sts.out_free) begin
                    o_cmd.wr_out = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// ===== sv/xrg_dp.sv =====
`timescale 1ns / 1ps

module xrg_dp (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_valid,
    input  logic [xrg_pkg::IDX_W-1:0]  i_cfg_index,
    input  logic [xrg_pkg::WORD_W-1:0] i_cfg_data,
    input  xrg_pkg::t_in               i_in,
    input  logic                       i_out_ready,
    input  xrg_pkg::t_cmd              i_cmd,
    output xrg_pkg::t_sts              o_sts,
    output logic                       o_out_valid,
    output xrg_pkg::t_out              o_out
);
    import xrg_pkg::*;

    // configuration and generator state
    logic [1:0]        r_variant, n_variant;
    logic [WORD_W-1:0] r_seed_a, n_seed_a;
    logic [WORD_W-1:0] r_seed_b, n_seed_b;
    logic [WORD_W-1:0] r_w0, r_w1;
    logic              cfg_hit;

    // item registers
    logic              r_cmd;
    logic [WORD_W-1:0] r_lo_in, r_hi_in;
    logic [WORD_W-1:0] r_raw, r_lo, r_mod, r_rem, r_dvd;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_bad;
    logic              r_out_valid;
    t_out              r_out;

    logic              is128, is32;
    logic [WORD_W-1:0] wmask;
    logic [WORD_W-1:0] a128, n0, n1, raw;
    logic [HALF_W-1:0] x32a, x32b, x32c;
    logic [WORD_W-1:0] x64a, x64b, x64c;
    logic [WORD_W-1:0] lo_m, hi_m, mod_m;
    logic [WORD_W:0]   trial;
    logic [WORD_W:0]   trial_sub;
    logic [WORD_W-1:0] bounded;

    assign is128 = r_variant[1];
    assign is32  = (r_variant == VAR_XS32);
    assign wmask = is32 ? {{(WORD_W-HALF_W){1'b0}}, {HALF_W{1'b1}}} : {WORD_W{1'b1}};

    always_comb begin
        n_variant = r_variant;
        n_seed_a  = r_seed_a;
        n_seed_b  = r_seed_b;
        cfg_hit   = 1'b0;
        if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_VARIANT: begin
                    n_variant = i_cfg_data[1:0];
                    cfg_hit   = 1'b1;
                end
                REG_SEED_A: begin
                    n_seed_a = i_cfg_data;
                    cfg_hit  = 1'b1;
                end
                REG_SEED_B: begin
                    n_seed_b = i_cfg_data;
                    cfg_hit  = 1'b1;
                end
                default: begin
                    cfg_hit = 1'b0;
                end
            endcase
        end
    end

    // one generator step
    always_comb begin
        x32a = r_w0[HALF_W-1:0] ^ (r_w0[HALF_W-1:0] << XS32_SH1);
        x32b = x32a ^ (x32a >> XS32_SH2);
        x32c = x32b ^ (x32b << XS32_SH3);
        x64a = r_w0 ^ (r_w0 << XS64_SH1);
        x64b = x64a ^ (x64a >> XS64_SH2);
        x64c = x64b ^ (x64b << XS64_SH3);
        a128 = r_w0 ^ (r_w0 << XS128_SH1);
        if (is128) begin
            n0  = r_w1;
            n1  = a128 ^ r_w1 ^ (a128 >> XS128_SH2) ^ (r_w1 >> XS128_SH3);
            raw = n1 + r_w1;
        end else if (is32) begin
            n0  = {{(WORD_W-HALF_W){1'b0}}, x32c};
            n1  = r_w1;
            raw = n0;
        end else begin
            n0  = x64c;
            n1  = r_w1;
            raw = x64c;
        end
    end

    assign lo_m  = r_lo_in & wmask;
    assign hi_m  = r_hi_in & wmask;
    assign mod_m = (hi_m - lo_m + {{(WORD_W-1){1'b0}}, 1'b1}) & wmask;

    assign o_sts.skip_div = !r_cmd || (mod_m == '0);
    assign o_sts.div_last = (r_cnt == {CNT_W{1'b1}});
    assign o_sts.out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_variant <= RST_VARIANT;
            r_seed_a  <= RST_SEED_A;
            r_seed_b  <= RST_SEED_B;
            r_w0      <= RST_SEED_A & {{(WORD_W-HALF_W){1'b0}}, {HALF_W{1'b1}}};
            r_w1      <= RST_SEED_B;
        end else begin
            r_variant <= n_variant;
            r_seed_a  <= n_seed_a;
            r_seed_b  <= n_seed_b;
            if (cfg_hit) begin
                if (n_variant[1]) begin
                    r_w0 <= (n_seed_a == '0) ? ZERO_FIX_A : n_seed_a;
                end else if (n_variant == VAR_XS32) begin
                    r_w0 <= n_seed_a & {{(WORD_W-HALF_W){1'b0}}, {HALF_W{1'b1}}};
                end else begin
                    r_w0 <= n_seed_a;
                end
                r_w1 <= (n_seed_b == '0) ? ZERO_FIX_B : n_seed_b;
            end else if (i_cmd.gen) begin
                r_w0 <= n0;
                r_w1 <= n1;
            end
        end
    end

    // restoring remainder, one bit a cycle
    assign trial     = {r_rem, r_dvd[WORD_W-1]};
    assign trial_sub = trial - {1'b0, r_mod};
    assign bounded   = (r_lo + r_rem) & wmask;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_cmd   <= i_in.cmd;
            r_lo_in <= i_in.range_low;
            r_hi_in <= i_in.range_high;
        end
        if (i_cmd.gen) begin
            r_raw <= raw & wmask;
            r_dvd <= raw & wmask;
            r_lo  <= lo_m;
            r_mod <= mod_m;
            r_rem <= '0;
            r_cnt <= '0;
            r_bad <= r_cmd && (mod_m == '0);
        end
        if (i_cmd.div_step) begin
            r_dvd <= r_dvd << 1;
            r_cnt <= r_cnt + 1'b1;
            if (!trial_sub[WORD_W]) begin
                r_rem <= trial_sub[WORD_W-1:0];
            end else begin
                r_rem <= trial[WORD_W-1:0];
            end
        end
        if (i_cmd.wr_out) begin
            r_out.value     <= (r_bad || !r_cmd) ? r_raw : bounded;
            r_out.bad_range <= r_bad;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.wr_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

// ===== sv/xorshift_random_generator.sv =====
`timescale 1ns / 1ps

// channel   signals                                  direction
// cfg       i_cfg_valid o_cfg_ready i_cfg_index       in
//           i_cfg_data
// in        i_in_valid o_in_ready i_in                in
// out       o_out_valid i_out_ready o_out             out
//
// raw item: after the accept come the generator step and the result write, which waits
// while the output register is full; the next item is taken after the write
// bounded item: a radix-2 remainder loop in between, one bit per cycle over 64 bits
// a finished result sits in the output register; the next item is accepted meanwhile
// reset loads variant 0 and the reset seeds into the generator, no clearing pass
// cfg writes are always taken; writes to index 0 to 2 reload the generator state

module xorshift_random_generator (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [xrg_pkg::IDX_W-1:0]  i_cfg_index,
    input  logic [xrg_pkg::WORD_W-1:0] i_cfg_data,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  xrg_pkg::t_in               i_in,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output xrg_pkg::t_out              o_out
);
    import xrg_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;

    assign o_cfg_ready = 1'b1;

    xrg_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_sts      (w_sts),
        .o_in_ready (o_in_ready),
        .o_cmd      (w_cmd)
    );

    xrg_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in        (i_in),
        .i_out_ready (i_out_ready),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .o_out_valid (o_out_valid),
        .o_out       (o_out)
    );

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input taken while an item is in progress");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.wr_out |-> (!o_out_valid || i_out_ready))
        else $error("result register overwritten before it was taken");

    a_one_command: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({w_cmd.load_in, w_cmd.gen, w_cmd.div_step, w_cmd.wr_out}))
        else $error("more than one datapath command in a cycle");

    a_result_then_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.wr_out |=> (o_out_valid && o_in_ready))
        else $error("result write did not return the block to idle");

endmodule
